// ----- rtl/core/b64c_pkg.sv -----
// Shared types, constants and alphabet functions for the Base64 stream codec.
// No dependencies; imported by every module of the codec.
package b64c_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DECODE_MODE  = 2'd0;
  localparam logic [1:0] CFG_URL_ALPHABET = 2'd1;
  localparam logic [1:0] CFG_PAD_OUTPUT   = 2'd2;

  // Job queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Characters.
  localparam logic [7:0] CHAR_PAD   = 8'h3D; // '='
  localparam logic [7:0] CHAR_PLUS  = 8'h2B; // '+'
  localparam logic [7:0] CHAR_SLASH = 8'h2F; // '/'
  localparam logic [7:0] CHAR_DASH  = 8'h2D; // '-'
  localparam logic [7:0] CHAR_UNDER = 8'h5F; // '_'

  // One job: the 1 to 4 results caused by one accepted item.
  typedef struct packed {
    logic [3:0][7:0] bytes;    // bytes[0] goes out first
    logic [1:0]      count_m1; // number of results minus one
    logic            has_data; // 0 for a bare end marker
    logic            bad;      // error flag of a bare end marker
    logic            last;     // final result of the job ends the message
  } job_t;

  // 6-bit value to alphabet character.
  function automatic logic [7:0] sym_char(input logic [5:0] v, input logic url);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v - 6'd26};
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v - 6'd52};
    end else if (v == 6'd62) begin
      c = url ? CHAR_DASH : CHAR_PLUS;
    end else begin
      c = url ? CHAR_UNDER : CHAR_SLASH;
    end
    return c;
  endfunction

  // Character to {valid, 6-bit value}.
  function automatic logic [6:0] sym_value(input logic [7:0] c, input logic url);
    logic [7:0] d;
    logic [6:0] r;
    d = 8'h00;
    r = 7'h00;
    if (c inside {[8'h41:8'h5A]}) begin
      d = c - 8'h41;
      r = {1'b1, d[5:0]};
    end else if (c inside {[8'h61:8'h7A]}) begin
      d = c - 8'h61 + 8'd26;
      r = {1'b1, d[5:0]};
    end else if (c inside {[8'h30:8'h39]}) begin
      d = c - 8'h30 + 8'd52;
      r = {1'b1, d[5:0]};
    end else if (url && c == CHAR_DASH) begin
      r = {1'b1, 6'd62};
    end else if (url && c == CHAR_UNDER) begin
      r = {1'b1, 6'd63};
    end else if (!url && c == CHAR_PLUS) begin
      r = {1'b1, 6'd62};
    end else if (!url && c == CHAR_SLASH) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/b64c_front.sv -----
// Front end: configuration registers, item intake, group state and job build.
// Depends on b64c_pkg.
module b64c_front import b64c_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic       cfg_data,
  input  logic       q_full,
  output logic       q_push,
  output job_t       q_job
);

  logic        decode_mode, url_alphabet, pad_output;
  logic [23:0] group_bits, group_bits_next;
  logic [1:0]  group_fill, group_fill_next;
  logic        pad_seen, pad_seen_next;
  logic        error_seen, error_seen_next;

  logic        accept;
  logic        emit;
  job_t        job;
  logic [2:0]  fill_inc;
  logic [23:0] enc_bits, enc_tail;
  logic [6:0]  sv;
  logic [23:0] dec_bits;

  assign full      = q_full;
  assign cfg_ready = 1'b1;
  assign accept    = push && !q_full;
  assign q_push    = accept && emit;
  assign q_job     = job;

  assign fill_inc = {1'b0, group_fill} + 3'd1;
  assign enc_bits = {group_bits[15:0], in_byte};
  assign enc_tail = (fill_inc == 3'd2) ? {enc_bits[15:0], 8'h00} : {enc_bits[7:0], 16'h0000};
  assign sv       = sym_value(in_byte, url_alphabet);
  assign dec_bits = {group_bits[17:0], sv[5:0]};

  always_comb begin
    group_bits_next = group_bits;
    group_fill_next = group_fill;
    pad_seen_next   = pad_seen;
    error_seen_next = error_seen;
    emit            = 1'b0;
    job             = '0;
    job.has_data    = 1'b1;
    job.last        = in_last;

    if (!decode_mode) begin
      if (fill_inc == 3'd3) begin
        emit           = 1'b1;
        job.bytes[0]   = sym_char(enc_bits[23:18], url_alphabet);
        job.bytes[1]   = sym_char(enc_bits[17:12], url_alphabet);
        job.bytes[2]   = sym_char(enc_bits[11:6], url_alphabet);
        job.bytes[3]   = sym_char(enc_bits[5:0], url_alphabet);
        job.count_m1   = 2'd3;
        group_bits_next = '0;
        group_fill_next = '0;
      end else begin
        group_bits_next = enc_bits;
        group_fill_next = fill_inc[1:0];
        if (in_last) begin
          // partial group flush
          emit         = 1'b1;
          job.bytes[0] = sym_char(enc_tail[23:18], url_alphabet);
          job.bytes[1] = sym_char(enc_tail[17:12], url_alphabet);
          if (fill_inc == 3'd2) begin
            job.bytes[2] = sym_char(enc_tail[11:6], url_alphabet);
            job.bytes[3] = CHAR_PAD;
            job.count_m1 = pad_output ? 2'd3 : 2'd2;
          end else begin
            job.bytes[2] = CHAR_PAD;
            job.bytes[3] = CHAR_PAD;
            job.count_m1 = pad_output ? 2'd3 : 2'd1;
          end
        end
      end
    end else begin
      if (!error_seen) begin
        if (in_byte == CHAR_PAD) begin
          pad_seen_next = 1'b1;
        end else if (pad_seen || !sv[6]) begin
          error_seen_next = 1'b1;
        end else if (fill_inc == 3'd4) begin
          emit            = 1'b1;
          job.bytes[0]    = dec_bits[23:16];
          job.bytes[1]    = dec_bits[15:8];
          job.bytes[2]    = dec_bits[7:0];
          job.count_m1    = 2'd2;
          group_bits_next = '0;
          group_fill_next = '0;
        end else begin
          group_bits_next = dec_bits;
          group_fill_next = fill_inc[1:0];
        end
      end
      // tail flush: 1 symbol -> 1 byte, 2 -> 1, 3 -> 2
      if (in_last && !error_seen_next && group_fill_next != 2'd0) begin
        emit = 1'b1;
        case (group_fill_next)
          2'd1: begin
            job.bytes[0] = {group_bits_next[5:0], 2'b00};
            job.count_m1 = 2'd0;
          end
          2'd2: begin
            job.bytes[0] = group_bits_next[11:4];
            job.count_m1 = 2'd0;
          end
          default: begin
            job.bytes[0] = group_bits_next[17:10];
            job.bytes[1] = group_bits_next[9:2];
            job.count_m1 = 2'd1;
          end
        endcase
      end
    end

    // nothing to flush at message end: bare end marker
    if (in_last && !emit) begin
      emit         = 1'b1;
      job.has_data = 1'b0;
      job.bad      = decode_mode && error_seen_next;
      job.count_m1 = 2'd0;
    end

    if (in_last) begin
      group_bits_next = '0;
      group_fill_next = '0;
      pad_seen_next   = 1'b0;
      error_seen_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      decode_mode  <= 1'b0;
      url_alphabet <= 1'b0;
      pad_output   <= 1'b1;
      group_bits   <= '0;
      group_fill   <= '0;
      pad_seen     <= 1'b0;
      error_seen   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DECODE_MODE: begin
          decode_mode <= cfg_data;
          group_bits  <= '0;
          group_fill  <= '0;
          pad_seen    <= 1'b0;
          error_seen  <= 1'b0;
        end
        CFG_URL_ALPHABET: url_alphabet <= cfg_data;
        CFG_PAD_OUTPUT:   pad_output   <= cfg_data;
        default: ;
      endcase
    end else if (accept) begin
      group_bits <= group_bits_next;
      group_fill <= group_fill_next;
      pad_seen   <= pad_seen_next;
      error_seen <= error_seen_next;
    end
  end

endmodule

// ----- rtl/core/b64c_queue.sv -----
// Small register FIFO of jobs between front and back.
// Depends on b64c_pkg.
module b64c_queue import b64c_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  job_t wr_job,
  output logic q_full,
  input  logic rd,
  output logic rd_valid,
  output job_t rd_job
);

  job_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wptr, rptr;
  logic [QCNT_W-1:0] cnt;

  assign q_full   = (cnt == QCNT_W'(QDEPTH));
  assign rd_valid = (cnt != '0);
  assign rd_job   = slots[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (wr) begin
        wptr <= wptr + 1'b1;
      end
      if (rd) begin
        rptr <= rptr + 1'b1;
      end
      case ({wr, rd})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

// ----- rtl/core/b64c_back.sv -----
// Back end: splits each job into results and holds the result output register.
// Depends on b64c_pkg.
module b64c_back import b64c_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  job_t       q_job,
  output logic       q_pop,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       has_data,
  output logic       bad_input,
  output logic       out_last
);

  job_t       cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       out_valid;
  logic       advance, cur_done;

  assign empty    = !out_valid;
  assign advance  = cur_valid && (!out_valid || pop);
  assign cur_done = (idx == cur.count_m1);
  assign q_pop    = q_valid && (!cur_valid || (advance && cur_done));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        cur_valid <= 1'b1;
        idx       <= '0;
      end else if (advance) begin
        if (cur_done) begin
          cur_valid <= 1'b0;
        end
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_job;
    end
    if (advance) begin
      out_byte  <= cur.has_data ? cur.bytes[idx] : 8'h00;
      has_data  <= cur.has_data;
      bad_input <= cur.bad;
      out_last  <= cur.last && cur_done;
    end
  end

endmodule

// ----- rtl/core/base64_stream_codec.sv -----
// Top level of the streaming Base64 codec: front end, job queue, back end.
// Depends on b64c_pkg, b64c_front, b64c_queue and b64c_back.
//
// Streaming Base64 (RFC 4648) encoder/decoder, one byte per item on a queue-style
// interface (push/full in, empty/pop out). Encoding turns every 3 bytes into 4
// characters and flushes a partial group, with optional '=' fill, on the item
// flagged in_last; decoding turns 4 symbols into 3 bytes, drops trailing '=', and
// flushes a 1- to 3-symbol tail at message end. A decode error (bad character, or
// anything but '=' after '=') suppresses all later data of the message; its end
// comes out as a bare marker (has_data 0) with bad_input 1, and the whole message
// should be discarded. Every message ends with exactly one result with out_last 1.
// Rate: the front end takes one item per cycle unless the queue is full; the back
// end emits one result per cycle from its output register while pop keeps up, so
// encoding throughput is set by the result port (4 results per 3 items).
// A 4-entry job queue between the two absorbs bursts; push sees full only when
// that queue is full. Results pass the queue, current-job and output registers.
// Configuration writes (cfg_ready is always high) are to be made while the block
// is idle; writing decode_mode also clears the message state.
module base64_stream_codec import b64c_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  // item input
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  // result output
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       has_data,
  output logic       bad_input,
  output logic       out_last,
  // configuration write channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic       cfg_data
);

  logic q_full, q_push, q_valid, q_pop;
  job_t q_wr_job, q_rd_job;

  // front: config, intake, group assembly
  b64c_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_wr_job)
  );

  // jobs waiting for the result port
  b64c_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (q_push),
    .wr_job   (q_wr_job),
    .q_full   (q_full),
    .rd       (q_pop),
    .rd_valid (q_valid),
    .rd_job   (q_rd_job)
  );

  // back: one result per cycle while pop keeps up
  b64c_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_job     (q_rd_job),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .out_byte  (out_byte),
    .has_data  (has_data),
    .bad_input (bad_input),
    .out_last  (out_last)
  );

endmodule
